[hdl/ksat_pkg.sv]
// Package: shared widths, command codes, controller states and scan status type.
package ksat_pkg;

  localparam int KEY_W = 48;
  localparam int SUM_W = 32;
  localparam int AMT_W = 10;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

[hdl/keyed_sum_accumulator_table.sv]
// Top level: keyed sum accumulator table with memory-resident keys, sums and valid marks.
//
// Requests arrive on in_valid/in_stall with in_cmd (add, erase, query), in_key and
// in_amount. Each request gives one result on out_valid/out_stall: out_sum,
// out_found and out_full_error.
// A request is accepted only while the controller is idle. It then scans every
// table entry through one read port of the key and sum memories, one entry per
// cycle, takes a drain step for the last read and a finish step that writes any
// update to the matched or free entry and loads the output register.
// After reset a clearing pass writes an empty mark into every entry, one entry per
// cycle; no request is accepted meanwhile.
// A result waits in the output register while out_stall is high; the next request
// may be accepted and scanned meanwhile, and its finish step holds until the
// output register is free.
module keyed_sum_accumulator_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [ksat_pkg::KEY_W-1:0]  in_key,
  input  logic [ksat_pkg::AMT_W-1:0]  in_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ksat_pkg::SUM_W-1:0]  out_sum,
  output logic                        out_found,
  output logic                        out_full_error
);
  import ksat_pkg::*;

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

  state_t            state_r, state_nxt;
  logic [IDXW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]        req_cmd_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [AMT_W-1:0]  req_amt_r;

  logic [KEY_W:0]    key_mem [TABLE_ENTRIES];
  logic [SUM_W-1:0]  sum_mem [TABLE_ENTRIES];
  logic [KEY_W:0]    key_rd_r;
  logic [SUM_W-1:0]  sum_rd_r;
  logic              rd_vld_r;
  logic [IDXW-1:0]   rd_idx_r;
  logic              rd_en;

  logic              key_we, sum_we;
  logic [IDXW-1:0]   wr_addr;
  logic [KEY_W:0]    key_wdata;
  logic [SUM_W-1:0]  sum_wdata;

  scan_flags_t       flags;
  logic [IDXW-1:0]   hit_idx, free_idx;
  logic [SUM_W-1:0]  hit_sum;
  logic [SUM_W:0]    sat_sum;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r, res_sum;
  logic              out_found_r, res_found;
  logic              out_full_r, res_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !(out_valid_r && out_stall);
  assign rd_en    = (state_r == ST_SCAN);
  assign sat_sum  = {1'b0, hit_sum} + (SUM_W + 1)'(req_amt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd_r <= in_cmd;
      req_key_r <= in_key;
      req_amt_r <= in_amount;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    key_we    = 1'b0;
    sum_we    = 1'b0;
    wr_addr   = cnt_r;
    key_wdata = '0;
    sum_wdata = '0;
    out_load  = 1'b0;
    res_sum   = '0;
    res_found = 1'b0;
    res_full  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        key_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        wr_addr = flags.hit ? hit_idx : free_idx;
        unique case (req_cmd_r)
          CMD_ADD: begin
            if (flags.hit) begin
              res_found = 1'b1;
              sum_we    = 1'b1;
              sum_wdata = sat_sum[SUM_W] ? SUM_MAX : sat_sum[SUM_W-1:0];
            end else if (flags.free) begin
              key_we    = 1'b1;
              key_wdata = {1'b1, req_key_r};
              sum_we    = 1'b1;
              sum_wdata = SUM_W'(req_amt_r);
            end else begin
              res_full = 1'b1;
            end
          end
          CMD_ERASE: begin
            if (flags.hit) begin
              res_found = 1'b1;
              key_we    = 1'b1;
              key_wdata = {1'b0, req_key_r};
            end
          end
          CMD_QUERY: begin
            if (flags.hit) begin
              res_found = 1'b1;
              res_sum   = hit_sum;
            end
          end
          default: begin
          end
        endcase
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          key_we = 1'b0;
          sum_we = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[wr_addr] <= sum_wdata;
    end
    if (rd_en) begin
      sum_rd_r <= sum_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
  end

  ksat_scan #(
    .IDXW(IDXW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (accept),
    .rd_vld       (rd_vld_r),
    .rd_idx       (rd_idx_r),
    .rd_entry_vld (key_rd_r[KEY_W]),
    .rd_key       (key_rd_r[KEY_W-1:0]),
    .rd_sum       (sum_rd_r),
    .req_key      (req_key_r),
    .flags        (flags),
    .hit_idx      (hit_idx),
    .free_idx     (free_idx),
    .hit_sum      (hit_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r   <= res_sum;
      out_found_r <= res_found;
      out_full_r  <= res_full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sum        = out_sum_r;
  assign out_found      = out_found_r;
  assign out_full_error = out_full_r;

  a_found_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_full_r))
    else $error("result flags both found and full");

  a_sum_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_sum_r != '0) |-> out_found_r)
    else $error("nonzero sum without a match");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !key_we && !sum_we)
    else $error("table write during scan");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SCAN && cnt_r == '0)
    else $error("accepted request did not start a scan");

endmodule

[hdl/ksat_scan.sv]
// Scan tracker: compares streamed table entries and records first match and first free slot.
module ksat_scan #(
  parameter int IDXW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        rd_vld,
  input  logic [IDXW-1:0]             rd_idx,
  input  logic                        rd_entry_vld,
  input  logic [ksat_pkg::KEY_W-1:0]  rd_key,
  input  logic [ksat_pkg::SUM_W-1:0]  rd_sum,
  input  logic [ksat_pkg::KEY_W-1:0]  req_key,
  output ksat_pkg::scan_flags_t       flags,
  output logic [IDXW-1:0]             hit_idx,
  output logic [IDXW-1:0]             free_idx,
  output logic [ksat_pkg::SUM_W-1:0]  hit_sum
);
  import ksat_pkg::*;

  scan_flags_t      flags_r;
  logic [IDXW-1:0]  hit_idx_r;
  logic [IDXW-1:0]  free_idx_r;
  logic [SUM_W-1:0] hit_sum_r;
  logic             match;

  assign match = rd_vld && rd_entry_vld && (rd_key == req_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (start) begin
      flags_r <= '0;
    end else begin
      if (match && !flags_r.hit) begin
        flags_r.hit <= 1'b1;
      end
      if (rd_vld && !rd_entry_vld && !flags_r.free) begin
        flags_r.free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!start && match && !flags_r.hit) begin
      hit_idx_r <= rd_idx;
      hit_sum_r <= rd_sum;
    end
    if (!start && rd_vld && !rd_entry_vld && !flags_r.free) begin
      free_idx_r <= rd_idx;
    end
  end

  assign flags    = flags_r;
  assign hit_idx  = hit_idx_r;
  assign free_idx = free_idx_r;
  assign hit_sum  = hit_sum_r;

  a_hit_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    !flags_r.hit && !start ##1 flags_r.hit |-> $past(match))
    else $error("hit flag set without a matching entry");

  a_free_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    !flags_r.free && !start ##1 flags_r.free |-> $past(rd_vld && !rd_entry_vld))
    else $error("free flag set without an empty entry");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> flags_r == '0)
    else $error("scan status not cleared at start");

endmodule

[verif/keyed_sum_accumulator_table_tb.sv]
// Testbench for keyed_sum_accumulator_table: randomized requests checked against a table predictor.
module keyed_sum_accumulator_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ksat_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_POOL = 96;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    int               gap;
    bit               drain_first;
  } request_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             found;
    logic             full_error;
  } table_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_cmd = CMD_ADD;
  logic [KEY_W-1:0] in_key = '0;
  logic [AMT_W-1:0] in_amount = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SUM_W-1:0] out_sum;
  logic             out_found;
  logic             out_full_error;

  request_t         pending_requests[$];
  table_result_t    expected_results[$];
  request_t         request_on_bus;

  logic [KEY_W-1:0] tbl_key[TABLE_ENTRIES];
  logic [SUM_W-1:0] tbl_sum[TABLE_ENTRIES];
  bit               tbl_used[TABLE_ENTRIES] = '{default: 1'b0};

  logic [KEY_W-1:0] key_pool[KEY_POOL];
  bit               sender_calm = 1'b0;
  int               stall_left = 0;
  int               results_seen = 0;
  int               fail_count = 0;
  int               cycle_count = 0;

  keyed_sum_accumulator_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sum(out_sum),
    .out_found(out_found),
    .out_full_error(out_full_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic table_result_t apply_request(request_t r);
    table_result_t res;
    int hit;
    int free_slot;
    logic [SUM_W:0] wide;
    res = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && tbl_used[i] && tbl_key[i] == r.key) hit = i;
      if (free_slot < 0 && !tbl_used[i]) free_slot = i;
    end
    case (r.cmd)
      CMD_ADD: begin
        if (hit >= 0) begin
          wide = {1'b0, tbl_sum[hit]} + (SUM_W + 1)'(r.amount);
          tbl_sum[hit] = (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
          res.found = 1'b1;
        end else if (free_slot >= 0) begin
          tbl_key[free_slot] = r.key;
          tbl_sum[free_slot] = SUM_W'(r.amount);
          tbl_used[free_slot] = 1'b1;
        end else begin
          res.full_error = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          res.found = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (hit >= 0) begin
          res.sum = tbl_sum[hit];
          res.found = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic request_t make_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [AMT_W-1:0] amount);
    request_t r;
    r.cmd = cmd;
    r.key = key;
    r.amount = amount;
    r.gap = sender_calm ? 0 : $urandom_range(0, 15);
    r.drain_first = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_request(request_on_bus));
      if (in_valid && in_stall) begin
        // hold the request until taken
      end else if (pending_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_requests[0].drain_first && expected_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_requests[0].gap != 0) begin
        if (!in_stall) pending_requests[0].gap = pending_requests[0].gap - 1;
        in_valid <= 1'b0;
      end else begin
        request_on_bus = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_cmd <= request_on_bus.cmd;
        in_key <= request_on_bus.key;
        in_amount <= request_on_bus.amount;
      end
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_sum, out_found, out_full_error};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: sum %h found %b full_error %b",
                   out_sum, out_found, out_full_error);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"mismatch: expected sum %h found %b full_error %b, ",
                      "got sum %h found %b full_error %b"},
                     want.sum, want.found, want.full_error,
                     out_sum, out_found, out_full_error);
        end
      end
      results_seen++;
      stall_left = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
      out_stall <= (stall_left != 0);
    end else if (out_valid === 1'b1 && stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    request_t r;
    int pick;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'({$urandom, $urandom});

    sender_calm = 1'b0;
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_ERASE, key_pool[0], 10'd1023));
    pending_requests.push_back(make_request(CMD_ADD, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_ADD, key_pool[0], 10'd1023));
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_ADD, key_pool[1], 10'd1023));
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[1], 10'd1023));
    pending_requests.push_back(make_request(CMD_ADD, key_pool[0], 10'd1));
    pending_requests.push_back(make_request(CMD_UNUSED, key_pool[1], 10'd1023));
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[1], 10'd0));
    pending_requests.push_back(make_request(CMD_ERASE, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_ADD, key_pool[2], 10'd5));
    pending_requests.push_back(make_request(CMD_ERASE, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_ADD, key_pool[0], 10'd7));
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[2], 10'd0));
    pending_requests.push_back(make_request(CMD_QUERY, key_pool[0], 10'd0));
    pending_requests.push_back(make_request(CMD_UNUSED, key_pool[0], 10'd0));

    // fill the table past capacity with distinct keys
    for (int i = 3; i < 73; i++) begin
      sender_calm = (i >= 40 && i < 60);
      r = make_request(CMD_ADD, key_pool[i], AMT_W'($urandom_range(0, 1023)));
      r.drain_first = (i == 3);
      pending_requests.push_back(r);
    end

    for (int i = 0; i < 310; i++) begin
      sender_calm = (i % 60) < 15;
      pick = $urandom_range(0, 99);
      if (pick < 45)
        r = make_request(CMD_ADD, key_pool[$urandom_range(0, KEY_POOL - 1)],
                         AMT_W'($urandom_range(0, 1023)));
      else if (pick < 65)
        r = make_request(CMD_ERASE, key_pool[$urandom_range(0, KEY_POOL - 1)],
                         AMT_W'($urandom_range(0, 1023)));
      else if (pick < 90)
        r = make_request(CMD_QUERY, key_pool[$urandom_range(0, KEY_POOL - 1)],
                         AMT_W'($urandom_range(0, 1023)));
      else if (pick < 95)
        r = make_request(CMD_UNUSED, key_pool[$urandom_range(0, KEY_POOL - 1)],
                         AMT_W'($urandom_range(0, 1023)));
      else
        r = make_request(CMD_ADD, KEY_W'({$urandom, $urandom}),
                         AMT_W'($urandom_range(0, 1023)));
      r.drain_first = (i == 150);
      pending_requests.push_back(r);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TABLE_ENTRIES + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
